/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL. Every check is clocked on aclk and is
// disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true at a clock edge.
`define KIO_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define KIO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kio_pkg.sv */
// ----------------------------------------------------------------------------
// kio_pkg
// Shared constants, types and fixed-point helpers of the intermittent
// observation Kalman estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kio_pkg;

    localparam int STATE_DIM = 4;
    localparam int NN        = STATE_DIM * STATE_DIM;
    localparam int IDX_W     = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;
    localparam int ELEM_W    = (NN > 1) ? $clog2(NN) : 1;
    localparam int DIV_STEPS = 48;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [ELEM_W-1:0] elem_t;

    typedef enum logic [0:0] {OP_LOAD, OP_STEP} item_op_t;
    typedef enum logic [1:0] {MAT_A, MAT_Q, MAT_C, MAT_R} coef_mat_t;

    // Computation phases of one step.
    typedef enum logic [3:0] {
        PH_XN, PH_AP, PH_PN, PH_PC, PH_S, PH_INN, PH_GAIN, PH_XUPD, PH_PUPD
    } phase_t;

    // Datapath commands.
    typedef enum logic [3:0] {
        DP_NONE, DP_LOAD, DP_START, DP_CLR, DP_MUL, DP_ACC, DP_STORE,
        DP_DIV, DP_COMMIT, DP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_MUL, ST_ACC, ST_STORE, ST_DIV, ST_DIVWAIT,
        ST_CHECK, ST_COMMIT, ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        phase_t phase;
        idx_t   i;
        idx_t   j;
        idx_t   k;
    } cmd_t;

    typedef struct packed {
        logic s_pos;
        logic div_done;
    } status_t;

    // Row-major element address.
    function automatic elem_t elem_addr(input idx_t r, input idx_t c);
        int a;
        a = int'(r) * STATE_DIM + int'(c);
        return elem_t'(a);
    endfunction

    // Saturating 64-bit addition.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Saturating 32-bit addition.
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? S32_MIN : S32_MAX;
        end
        return s[31:0];
    endfunction

    // Saturating 32-bit subtraction.
    function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? S32_MIN : S32_MAX;
        end
        return s[31:0];
    endfunction

    // Q32.32 to Q16.16: round half up, then saturate.
    function automatic logic signed [31:0] narrow(input logic signed [63:0] acc);
        logic signed [63:0] t;
        if (acc > 64'sh0000_7FFF_FFFF_0000) begin
            return S32_MAX;
        end
        if (acc < 64'shFFFF_8000_0000_0000) begin
            return S32_MIN;
        end
        t = acc + 64'sd32768;
        return t[47:16];
    endfunction

endpackage

`default_nettype wire

/* rtl/kio_div.sv */
// ----------------------------------------------------------------------------
// kio_div
// Restoring divider for the Kalman gain: (num * 2^16) / den, truncated toward
// zero and saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kio_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [31:0] num,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quotient
);
    import kio_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [47:0]          num_reg;
    logic [31:0]          rem_reg;
    logic [47:0]          quo_reg;
    logic [31:0]          den_reg;
    logic                 neg_reg;

    logic [31:0] num_mag;
    logic [31:0] trial;
    logic [32:0] diff;

    // Magnitude of the numerator; the most negative value maps to 2^31.
    assign num_mag = num[31] ? (32'd0 - 32'(num)) : 32'(num);

    assign trial = {rem_reg[30:0], num_reg[47]};
    assign diff  = {1'b0, trial} - {1'b0, den_reg};

    // Iteration and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= {num_mag, 16'h0000};
                rem_reg  <= '0;
                quo_reg  <= '0;
                den_reg  <= 32'(den);
                neg_reg  <= num[31];
            end else if (busy_reg) begin
                num_reg <= {num_reg[46:0], 1'b0};
                if (!diff[32]) begin
                    rem_reg <= diff[31:0];
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Apply the sign and saturate to 32 bits.
    always_comb begin
        if (neg_reg) begin
            if (quo_reg >= 48'h0000_8000_0000) begin
                quotient = S32_MIN;
            end else begin
                quotient = 32'sd0 - $signed(quo_reg[31:0]);
            end
        end else begin
            if (quo_reg > 48'h0000_7FFF_FFFF) begin
                quotient = S32_MAX;
            end else begin
                quotient = $signed(quo_reg[31:0]);
            end
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

/* rtl/kio_ctrl.sv */
// ----------------------------------------------------------------------------
// kio_ctrl
// Sequencer of the estimator: walks the phases and loop indices of the time
// and measurement updates and issues one datapath command per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kio_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_op,
    input  wire logic             s_packet_arrived,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [1:0]            m_estimate_index,
    output logic                  m_update_skipped,
    output logic                  m_last,
    output kio_pkg::cmd_t         cmd,
    input  wire kio_pkg::status_t status
);
    import kio_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    idx_t        i_reg, i_next;
    idx_t        j_reg, j_next;
    idx_t        k_reg, k_next;
    logic        skip_reg, skip_next;

    logic        last_i, last_j, last_k;
    logic        uses_i, uses_j, full_k;
    ctrl_state_t loop_start;

    assign last_i = (i_reg == idx_t'(STATE_DIM - 1));
    assign last_j = (j_reg == idx_t'(STATE_DIM - 1));
    assign last_k = (k_reg == idx_t'(STATE_DIM - 1));

    // Loop shape of each phase.
    always_comb begin
        uses_i = !(phase_reg == PH_S || phase_reg == PH_INN);
        uses_j = (phase_reg == PH_AP || phase_reg == PH_PN || phase_reg == PH_PUPD);
        full_k = !(phase_reg == PH_GAIN || phase_reg == PH_XUPD || phase_reg == PH_PUPD);
        loop_start = (phase_reg == PH_GAIN) ? ST_DIV : ST_CLR;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_XN;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            skip_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            skip_reg  <= skip_next;
        end
    end

    // Next state and loop counters.
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        skip_next  = skip_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op == OP_STEP) begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    skip_next  = 1'b0;
                    phase_next = s_packet_arrived ? PH_PC : PH_XN;
                    state_next = ST_CLR;
                end
            end
            ST_CLR: begin
                k_next     = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (full_k && !last_k) begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_MUL;
                end else begin
                    k_next     = '0;
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                if (uses_j && !last_j) begin
                    j_next     = j_reg + 1'b1;
                    state_next = loop_start;
                end else if (uses_i && !last_i) begin
                    j_next     = '0;
                    i_next     = i_reg + 1'b1;
                    state_next = loop_start;
                end else begin
                    i_next = '0;
                    j_next = '0;
                    unique case (phase_reg)
                        PH_XN: begin
                            phase_next = PH_AP;
                            state_next = ST_CLR;
                        end
                        PH_AP: begin
                            phase_next = PH_PN;
                            state_next = ST_CLR;
                        end
                        PH_PN:   state_next = ST_COMMIT;
                        PH_PC: begin
                            phase_next = PH_S;
                            state_next = ST_CLR;
                        end
                        PH_S:    state_next = ST_CHECK;
                        PH_INN: begin
                            phase_next = PH_GAIN;
                            state_next = ST_DIV;
                        end
                        PH_GAIN: begin
                            phase_next = PH_XUPD;
                            state_next = ST_CLR;
                        end
                        PH_XUPD: begin
                            phase_next = PH_PUPD;
                            state_next = ST_CLR;
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_DIV: begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (status.div_done) begin
                    state_next = ST_STORE;
                end
            end
            ST_CHECK: begin
                // A variance that is not positive skips the correction.
                if (status.s_pos) begin
                    phase_next = PH_INN;
                    state_next = ST_CLR;
                end else begin
                    skip_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_COMMIT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_i) begin
                        i_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        cmd.op    = DP_NONE;
        cmd.phase = phase_reg;
        cmd.i     = i_reg;
        cmd.j     = j_reg;
        cmd.k     = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op = (s_op == OP_STEP) ? DP_START : DP_LOAD;
                end
            end
            ST_CLR:     cmd.op = DP_CLR;
            ST_MUL:     cmd.op = DP_MUL;
            ST_ACC:     cmd.op = DP_ACC;
            ST_STORE:   cmd.op = DP_STORE;
            ST_DIV:     cmd.op = DP_DIV;
            ST_COMMIT:  cmd.op = DP_COMMIT;
            ST_OUT:     cmd.op = DP_OUT;
            default:    cmd.op = DP_NONE;
        endcase
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = (state_reg == ST_OUT);
    assign m_last           = (state_reg == ST_OUT) && last_i;
    assign m_update_skipped = skip_reg;
    assign m_estimate_index = 2'(i_reg);

endmodule

`default_nettype wire

/* rtl/kio_dpath.sv */
// ----------------------------------------------------------------------------
// kio_dpath
// Datapath of the estimator: model and state registers, one shared
// multiply-accumulate unit, the result write-back and the gain divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kio_dpath (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire kio_pkg::cmd_t      cmd,
    output kio_pkg::status_t        status,
    input  wire logic [1:0]         s_coef_matrix,
    input  wire logic [3:0]         s_coef_index,
    input  wire logic signed [31:0] s_coef_value,
    input  wire logic signed [31:0] s_measurement,
    output logic signed [31:0]      est_value
);
    import kio_pkg::*;

    // State and model.
    logic signed [31:0] x_reg    [STATE_DIM];
    logic signed [31:0] p_reg    [NN];
    logic signed [31:0] a_reg    [NN];
    logic signed [31:0] q_reg    [NN];
    logic signed [31:0] c_reg    [STATE_DIM];
    logic signed [31:0] r_reg;

    // Intermediate results of one step.
    logic signed [31:0] ap_reg   [NN];
    logic signed [31:0] tmp_reg  [STATE_DIM];
    logic signed [31:0] gain_reg [STATE_DIM];
    logic signed [31:0] s_reg;
    logic signed [31:0] innov_reg;
    logic signed [31:0] y_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;

    elem_t a_addr, p_addr, ij_addr, ik_addr;
    idx_t  c_addr, x_addr, tmp_addr;
    logic signed [31:0] a_rd, p_rd, c_rd, x_rd, ap_rd, q_rd, tmp_rd, gain_rd;
    logic signed [31:0] op_a, op_b;
    logic signed [63:0] product, acc_init;
    logic signed [31:0] acc_narrow, pupd_val;
    logic signed [31:0] div_quot;
    logic               div_done;
    coef_mat_t          load_mat;

    assign ij_addr = elem_addr(cmd.i, cmd.j);
    assign ik_addr = elem_addr(cmd.i, cmd.k);

    // One read address per array, chosen by phase (x's also by DP_OUT).
    always_comb begin
        a_addr   = (cmd.phase == PH_PN) ? elem_addr(cmd.j, cmd.k) : ik_addr;
        unique case (cmd.phase)
            PH_AP:   p_addr = elem_addr(cmd.k, cmd.j);
            PH_PC:   p_addr = ik_addr;
            default: p_addr = ij_addr;
        endcase
        c_addr   = (cmd.phase == PH_PUPD) ? cmd.j : cmd.k;
        x_addr   = (cmd.op == DP_OUT || cmd.phase == PH_XUPD) ? cmd.i : cmd.k;
        tmp_addr = (cmd.phase == PH_S) ? cmd.k : cmd.i;
    end

    assign a_rd    = a_reg[a_addr];
    assign p_rd    = p_reg[p_addr];
    assign c_rd    = c_reg[c_addr];
    assign x_rd    = x_reg[x_addr];
    assign ap_rd   = ap_reg[ik_addr];
    assign q_rd    = q_reg[ij_addr];
    assign tmp_rd  = tmp_reg[tmp_addr];
    assign gain_rd = gain_reg[cmd.i];

    // Multiplier operands.
    always_comb begin
        unique case (cmd.phase)
            PH_XN: begin
                op_a = a_rd;
                op_b = x_rd;
            end
            PH_AP: begin
                op_a = a_rd;
                op_b = p_rd;
            end
            PH_PN: begin
                op_a = ap_rd;
                op_b = a_rd;
            end
            PH_PC: begin
                op_a = p_rd;
                op_b = c_rd;
            end
            PH_S: begin
                op_a = c_rd;
                op_b = tmp_rd;
            end
            PH_INN: begin
                op_a = c_rd;
                op_b = x_rd;
            end
            PH_XUPD: begin
                op_a = gain_rd;
                op_b = innov_reg;
            end
            PH_PUPD: begin
                op_a = gain_rd;
                op_b = c_rd;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // The innovation subtracts its products.
    always_comb begin
        logic signed [63:0] raw;
        raw = 64'(op_a) * 64'(op_b);
        product = (cmd.phase == PH_INN) ? (64'sd0 - raw) : raw;
    end

    // Accumulator start value: a Q16.16 term lifted to Q32.32.
    always_comb begin
        unique case (cmd.phase)
            PH_PN:   acc_init = {{16{q_rd[31]}}, q_rd, 16'h0000};
            PH_S:    acc_init = {{16{r_reg[31]}}, r_reg, 16'h0000};
            PH_INN:  acc_init = {{16{y_reg[31]}}, y_reg, 16'h0000};
            default: acc_init = '0;
        endcase
    end

    assign acc_narrow = narrow(acc_reg);

    // Covariance correction, clamped at zero.
    always_comb begin
        logic signed [31:0] v;
        v = sat_sub32(p_rd, acc_narrow);
        pupd_val = v[31] ? 32'sd0 : v;
    end

    assign load_mat = coef_mat_t'(s_coef_matrix);

    // Register file updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < STATE_DIM; n++) begin
                x_reg[n] <= '0;
                c_reg[n] <= '0;
            end
            for (int n = 0; n < NN; n++) begin
                p_reg[n] <= (n % (STATE_DIM + 1) == 0) ? ONE_Q16 : 32'sd0;
                a_reg[n] <= '0;
                q_reg[n] <= '0;
            end
            r_reg <= '0;
        end else begin
            unique case (cmd.op)
                DP_LOAD: begin
                    // Loads beyond the target's size are dropped.
                    unique case (load_mat)
                        MAT_A: begin
                            if (int'(s_coef_index) < NN) begin
                                a_reg[elem_t'(s_coef_index)] <= s_coef_value;
                            end
                        end
                        MAT_Q: begin
                            if (int'(s_coef_index) < NN) begin
                                q_reg[elem_t'(s_coef_index)] <= s_coef_value;
                            end
                        end
                        MAT_C: begin
                            if (int'(s_coef_index) < STATE_DIM) begin
                                c_reg[idx_t'(s_coef_index)] <= s_coef_value;
                            end
                        end
                        default: begin
                            if (s_coef_index == 4'd0) begin
                                r_reg <= s_coef_value;
                            end
                        end
                    endcase
                end
                DP_START: y_reg    <= s_measurement;
                DP_CLR:   acc_reg  <= acc_init;
                DP_MUL:   prod_reg <= product;
                DP_ACC:   acc_reg  <= sat_add64(acc_reg, prod_reg);
                DP_STORE: begin
                    unique case (cmd.phase)
                        PH_XN:   tmp_reg[cmd.i]    <= acc_narrow;
                        PH_AP:   ap_reg[ij_addr]   <= acc_narrow;
                        PH_PN:   p_reg[ij_addr]    <= acc_narrow;
                        PH_PC:   tmp_reg[cmd.i]    <= acc_narrow;
                        PH_S:    s_reg             <= acc_narrow;
                        PH_INN:  innov_reg         <= acc_narrow;
                        PH_GAIN: gain_reg[cmd.i]   <= div_quot;
                        PH_XUPD: x_reg[cmd.i]      <= sat_add32(x_rd, acc_narrow);
                        PH_PUPD: p_reg[ij_addr]    <= pupd_val;
                        default: ;
                    endcase
                end
                DP_COMMIT: begin
                    for (int n = 0; n < STATE_DIM; n++) begin
                        x_reg[n] <= tmp_reg[n];
                    end
                end
                default: ;
            endcase
        end
    end

    // Gain divider: P C^T element over the innovation variance.
    kio_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.op == DP_DIV),
        .num      (tmp_rd),
        .den      (s_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign status.s_pos    = !s_reg[31] && (s_reg != 32'sd0);
    assign status.div_done = div_done;
    assign est_value       = x_rd;

endmodule

`default_nettype wire

/* rtl/kalman_intermittent_observer.sv */
// ----------------------------------------------------------------------------
// kalman_intermittent_observer
// Scalar-measurement Kalman estimator for observations sent over a lossy
// link. Q16.16 arithmetic, with products accumulated in Q32.32.
//
// Usage:
//   The s_ channel takes load items (s_op = 0), which write one word of A, Q,
//   C or R and produce nothing, and step items (s_op = 1).
//   A step with s_packet_arrived = 0 runs the time update, one with 1 runs
//   the measurement update. Each step returns four transfers on the m_
//   channel, one per estimate element, m_last on the final one.
//   A time update runs 144 multiply-accumulates on the single shared
//   multiplier; a measurement update uses it and four gain divisions.
//   One item is in flight at a time.
//   Reset (aresetn low, synchronous) clears the estimate and the model and
//   sets the covariance to identity. A stalled receiver holds the current
//   result; no new item is accepted until all four results are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kalman_intermittent_observer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [1:0]         s_coef_matrix,
    input  wire logic [3:0]         s_coef_index,
    input  wire logic signed [31:0] s_coef_value,
    input  wire logic signed [31:0] s_measurement,
    input  wire logic               s_packet_arrived,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_estimate_index,
    output logic signed [31:0]      m_estimate_value,
    output logic                    m_update_skipped,
    output logic                    m_last
);
    import kio_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    kio_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_packet_arrived (s_packet_arrived),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_estimate_index (m_estimate_index),
        .m_update_skipped (m_update_skipped),
        .m_last           (m_last),
        .cmd              (cmd),
        .status           (status)
    );

    // Arithmetic and storage.
    kio_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_coef_matrix (s_coef_matrix),
        .s_coef_index  (s_coef_index),
        .s_coef_value  (s_coef_value),
        .s_measurement (s_measurement),
        .est_value     (m_estimate_value)
    );

    // Checks on the sequencing.
    `KIO_ASSERT_NEVER(a_no_overlap, s_ready && m_valid, "input taken while results pending")
    `KIO_ASSERT_NEVER(a_last_valid, m_last && !m_valid, "last flag without a result")
    `KIO_ASSERT_NEXT(a_idle_after_last, m_valid && m_ready && m_last, s_ready, "not idle after step")
    `KIO_ASSERT_NEXT(a_skip_steady, m_valid && m_ready && !m_last, $stable(m_update_skipped), "skip flag changed within a step")

endmodule

`default_nettype wire
